@@ src/chi_square_tail_probability_top_assert.svh @@
// Assertion macros for the chi-square tail probability block.
`ifndef CHI_SQUARE_TAIL_PROBABILITY_TOP_ASSERT_SVH
`define CHI_SQUARE_TAIL_PROBABILITY_TOP_ASSERT_SVH
`ifndef NO_ASSERTIONS
// Same-cycle implication, checked on every rising clock edge out of reset.
`define CSQ_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// Next-cycle implication.
`define CSQ_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define CSQ_ASSERT_SAME(label, ante, cons)
`define CSQ_ASSERT_NEXT(label, ante, cons)
`endif
`endif

@@ src/csq_pkg.sv @@
package csq_pkg;

    typedef struct packed {
        logic [6:0]  degrees_of_freedom;
        logic [21:0] chi_square;
    } t_in_item;

    typedef struct packed {
        logic [31:0] upper_prob;
        logic [31:0] lower_prob;
    } t_out_item;

    typedef enum logic [4:0] {
        OP_EXP_INIT_F,
        OP_EXP_STEP_F,
        OP_EXP_INIT_1,
        OP_EXP_STEP_1,
        OP_SQM_INIT,
        OP_SQM_MUL,
        OP_SQM_SQR,
        OP_SQRT,
        OP_LEAD_ZE,
        OP_LEAD_PHI,
        OP_NRM_INIT,
        OP_NRM_STEP,
        OP_NRM_FAIL,
        OP_ODD_INIT,
        OP_EVEN_INIT,
        OP_SER_STEP,
        OP_FINISH
    } t_op;

    typedef struct packed {
        logic go;
        t_op  op;
    } t_cmd;

    typedef struct packed {
        logic done;
        logic k_zero;
        logic k_lt_exp;
        logic k_lt_df;
        logic k_lt_nrm;
        logic odd;
        logic nrm_conv;
    } t_status;

    localparam logic [63:0] Q62_ONE      = 64'h4000_0000_0000_0000;
    localparam logic [63:0] Q62_HALF     = 64'h2000_0000_0000_0000;
    localparam logic [63:0] INV_SQRT_2PI = 64'd1839796536686825613;
    localparam logic [63:0] F_ONE        = 64'h0000_0000_0002_0000;
    localparam logic [63:0] RND_HALF     = 64'h0000_0000_4000_0000;
    localparam logic [63:0] SQRT_BIT0    = 64'h4000_0000_0000_0000;
    localparam logic [21:0] X_MAX        = 22'd2621440;
    localparam logic [7:0]  EXP_TERMS    = 8'd20;
    localparam logic [7:0]  EXP_BITS     = 8'd5;
    localparam logic [31:0] Q31_ONE      = 32'h8000_0000;
    localparam logic [5:0]  SH_EXP       = 6'd17;
    localparam logic [5:0]  SH_SER       = 6'd16;
    localparam logic [5:0]  SH_Q62       = 6'd62;
    localparam logic [5:0]  SH_LEAD      = 6'd28;
    localparam logic [4:0]  SQRT_LAST    = 5'd31;
    localparam logic [4:0]  DIV_LAST     = 5'd17;
    localparam logic [1:0]  MUL_LAST     = 2'd3;

endpackage

@@ src/chi_square_tail_probability_top.sv @@
// Chi-square tail probabilities: each transaction carries a degrees-of-freedom
// count (saturated to 1..MAX_DF) and a chi-square value in Q6.16 (saturated to
// 40.0), and returns the upper tail Q and the lower tail 1-Q in Q1.31, where
// 2^31 means 1.0. One item is in flight at a time; the next item is taken as
// soon as the result is handed to the output register. Latency depends on df
// and x and is set by one shared multiply/divide unit: each series term takes
// a start, four 32x32 partial products, a shift select, a radix-16 divide by
// the term index, and the done/issue handshake; each 64x64 product takes the
// four partial products and the shift select. exp(-x/2) takes 40 terms plus up
// to 10 products; an even df adds (df/2 - 1) terms; an odd df adds a square
// root, two products, the normal-tail series (up to NORMAL_TERMS - 1 terms)
// and, for df of 3 or more, (df - 3)/2 terms.
module chi_square_tail_probability_top #(
    parameter int MAX_DF       = 64,
    parameter int NORMAL_TERMS = 100
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  csq_pkg::t_in_item   i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output csq_pkg::t_out_item  o_out_data
);

    csq_pkg::t_cmd      cmd;
    csq_pkg::t_status   status;
    csq_pkg::t_out_item dp_out;
    logic               emit;
    logic               out_free;
    logic               in_accept;

    logic               r_out_valid;
    csq_pkg::t_out_item r_out;

    // output register is free when empty or being drained this cycle
    assign out_free  = !r_out_valid || i_out_ready;
    assign in_accept = i_in_valid && o_in_ready;

    csq_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_out_free (out_free),
        .i_status   (status),
        .o_cmd      (cmd),
        .o_emit     (emit)
    );

    csq_dp #(
        .MAX_DF       (MAX_DF),
        .NORMAL_TERMS (NORMAL_TERMS)
    ) u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (in_accept),
        .i_in     (i_in_data),
        .i_cmd    (cmd),
        .o_status (status),
        .o_out    (dp_out)
    );

    // hold the finished result until the consumer takes the transaction
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            if (emit) begin
                r_out_valid <= 1'b1;
                r_out       <= dp_out;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

`include "chi_square_tail_probability_top_assert.svh"

    // busy right after taking a transaction
    `CSQ_ASSERT_NEXT(a_busy_after_accept, in_accept, !o_in_ready)
    // never overwrite a pending result
    `CSQ_ASSERT_SAME(a_no_overrun, emit, (!r_out_valid || i_out_ready))
    // the two tails always add up to one
    `CSQ_ASSERT_SAME(a_tails_sum, o_out_valid, ((o_out_data.upper_prob + o_out_data.lower_prob) == csq_pkg::Q31_ONE))

endmodule

@@ src/csq_arith.sv @@
module csq_arith (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic        i_div,
    input  logic [63:0] i_a,
    input  logic [63:0] i_b,
    input  logic [5:0]  i_shamt,
    input  logic [7:0]  i_dvs,
    output logic        o_done,
    output logic [63:0] o_res
);

    typedef enum logic [1:0] {S_IDLE, S_MUL, S_SEL, S_DIV} t_state;

    t_state       r_state;
    logic [4:0]   r_cnt;
    logic         r_div;
    logic [63:0]  r_a;
    logic [63:0]  r_b;
    logic [5:0]   r_shamt;
    logic [7:0]   r_dvs;
    logic [127:0] r_acc;
    logic [71:0]  r_quo;
    logic [7:0]   r_rem;
    logic         r_done;
    logic [63:0]  r_res;

    logic [31:0]  a_half;
    logic [31:0]  b_half;
    logic [63:0]  pp;
    logic [1:0]   pp_pos;
    logic [127:0] pp_sh;
    logic [127:0] shifted;
    logic [7:0]   rem;
    logic [8:0]   trial;
    logic         ge;
    logic [3:0]   qbits;
    logic [71:0]  n_quo;

    // 32x32 partial product, one per cycle
    assign a_half  = r_cnt[0] ? r_a[63:32] : r_a[31:0];
    assign b_half  = r_cnt[1] ? r_b[63:32] : r_b[31:0];
    assign pp      = a_half * b_half;
    assign pp_pos  = {1'b0, r_cnt[0]} + {1'b0, r_cnt[1]};
    assign pp_sh   = {64'b0, pp} << {pp_pos, 5'b0};
    assign shifted = r_acc >> r_shamt;

    // four restoring division steps per cycle on the narrow remainder
    always_comb begin
        rem   = r_rem;
        trial = '0;
        ge    = 1'b0;
        qbits = '0;
        for (int i = 3; i >= 0; i--) begin
            trial    = {rem, r_quo[68 + i]};
            ge       = trial >= {1'b0, r_dvs};
            qbits[i] = ge;
            rem      = ge ? 8'(trial - {1'b0, r_dvs}) : trial[7:0];
        end
    end

    assign n_quo = {r_quo[67:0], qbits};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_done  <= 1'b0;
            r_cnt   <= '0;
        end else begin
            r_done <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        r_a     <= i_a;
                        r_b     <= i_b;
                        r_div   <= i_div;
                        r_shamt <= i_shamt;
                        r_dvs   <= i_dvs;
                        r_acc   <= '0;
                        r_cnt   <= '0;
                        r_state <= S_MUL;
                    end
                end
                S_MUL: begin
                    r_acc <= r_acc + pp_sh;
                    r_cnt <= r_cnt + 5'd1;
                    if (r_cnt[1:0] == csq_pkg::MUL_LAST) begin
                        r_state <= S_SEL;
                    end
                end
                S_SEL: begin
                    if (r_div) begin
                        r_quo   <= shifted[71:0];
                        r_rem   <= '0;
                        r_cnt   <= '0;
                        r_state <= S_DIV;
                    end else begin
                        r_res   <= shifted[63:0];
                        r_done  <= 1'b1;
                        r_state <= S_IDLE;
                    end
                end
                S_DIV: begin
                    r_quo <= n_quo;
                    r_rem <= rem;
                    r_cnt <= r_cnt + 5'd1;
                    if (r_cnt == csq_pkg::DIV_LAST) begin
                        r_res   <= n_quo[63:0];
                        r_done  <= 1'b1;
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_done = r_done;
    assign o_res  = r_res;

endmodule

@@ src/csq_dp.sv @@
module csq_dp #(
    parameter int MAX_DF       = 64,
    parameter int NORMAL_TERMS = 100
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_load,
    input  csq_pkg::t_in_item   i_in,
    input  csq_pkg::t_cmd       i_cmd,
    output csq_pkg::t_status    o_status,
    output csq_pkg::t_out_item  o_out
);

    localparam logic [7:0] DF_MAX  = 8'(MAX_DF);
    localparam logic [7:0] NRM_LIM = 8'(2 * NORMAL_TERMS);

    logic [7:0]  r_df;
    logic [21:0] r_x;
    logic [63:0] r_e;
    logic [63:0] r_pw;
    logic [63:0] r_t;
    logic [63:0] r_s;
    logic [63:0] r_p;
    logic [63:0] r_lead;
    logic [63:0] r_z;
    logic [7:0]  r_k;
    logic        r_f1;
    logic        r_nz;
    logic        r_done;
    logic [63:0] r_sv;
    logic [63:0] r_sres;
    logic [63:0] r_sbit;
    logic [4:0]  r_scnt;
    logic        r_sbusy;

    logic [7:0]  df_in;
    logic [7:0]  df_sat;
    logic [21:0] x_sat;
    logic [4:0]  n_sh;
    logic        exp_bit;
    logic        ar_start;
    logic        ar_div;
    logic [63:0] ar_a;
    logic [63:0] ar_b;
    logic [5:0]  ar_sh;
    logic        ar_done;
    logic [63:0] ar_res;
    logic [63:0] cand;
    logic        sq_ge;
    logic [63:0] n_sv;
    logic [63:0] n_sres;
    logic [63:0] sum_pq;
    logic [63:0] q_clamp;
    logic [63:0] q_rnd;
    logic [31:0] up;

    assign df_in  = {1'b0, i_in.degrees_of_freedom};
    assign df_sat = (df_in == 8'd0) ? 8'd1 : ((df_in > DF_MAX) ? DF_MAX : df_in);
    assign x_sat  = (i_in.chi_square > csq_pkg::X_MAX) ? csq_pkg::X_MAX : i_in.chi_square;

    // integer bits of x/2 drive the square-and-multiply
    assign n_sh    = r_x[21:17] >> r_k[2:0];
    assign exp_bit = n_sh[0];

    always_comb begin
        ar_start = 1'b0;
        ar_div   = 1'b0;
        ar_a     = r_t;
        ar_b     = {42'b0, r_x};
        ar_sh    = csq_pkg::SH_SER;
        case (i_cmd.op)
            csq_pkg::OP_EXP_STEP_F, csq_pkg::OP_EXP_STEP_1: begin
                ar_start = i_cmd.go;
                ar_div   = 1'b1;
                ar_b     = r_f1 ? csq_pkg::F_ONE : {47'b0, r_x[16:0]};
                ar_sh    = csq_pkg::SH_EXP;
            end
            csq_pkg::OP_SQM_MUL: begin
                ar_start = i_cmd.go && exp_bit;
                ar_a     = r_e;
                ar_b     = r_pw;
                ar_sh    = csq_pkg::SH_Q62;
            end
            csq_pkg::OP_SQM_SQR: begin
                ar_start = i_cmd.go;
                ar_a     = r_pw;
                ar_b     = r_pw;
                ar_sh    = csq_pkg::SH_Q62;
            end
            csq_pkg::OP_LEAD_ZE: begin
                ar_start = i_cmd.go;
                ar_a     = r_z;
                ar_b     = r_e;
                ar_sh    = csq_pkg::SH_LEAD;
            end
            csq_pkg::OP_LEAD_PHI: begin
                ar_start = i_cmd.go;
                ar_b     = csq_pkg::INV_SQRT_2PI;
                ar_sh    = csq_pkg::SH_Q62;
            end
            csq_pkg::OP_NRM_STEP, csq_pkg::OP_SER_STEP: begin
                ar_start = i_cmd.go;
                ar_div   = 1'b1;
            end
            default: begin
                ar_start = 1'b0;
            end
        endcase
    end

    csq_arith u_arith (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (ar_start),
        .i_div   (ar_div),
        .i_a     (ar_a),
        .i_b     (ar_b),
        .i_shamt (ar_sh),
        .i_dvs   (r_k),
        .o_done  (ar_done),
        .o_res   (ar_res)
    );

    // bitwise square root, one result bit per cycle
    assign cand   = r_sres + r_sbit;
    assign sq_ge  = r_sv >= cand;
    assign n_sv   = sq_ge ? (r_sv - cand) : r_sv;
    assign n_sres = sq_ge ? ((r_sres >> 1) + r_sbit) : (r_sres >> 1);

    assign sum_pq = r_p + r_s;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done  <= 1'b0;
            r_sbusy <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_load) begin
                r_df <= df_sat;
                r_x  <= x_sat;
            end
            if (r_sbusy) begin
                r_sv   <= n_sv;
                r_sres <= n_sres;
                r_sbit <= r_sbit >> 2;
                r_scnt <= r_scnt + 5'd1;
                if (r_scnt == csq_pkg::SQRT_LAST) begin
                    r_z     <= n_sres;
                    r_sbusy <= 1'b0;
                    r_done  <= 1'b1;
                end
            end
            if (ar_done) begin
                r_done <= 1'b1;
                case (i_cmd.op)
                    csq_pkg::OP_EXP_STEP_F, csq_pkg::OP_EXP_STEP_1: begin
                        r_t <= csq_pkg::Q62_ONE - ar_res;
                        r_k <= r_k - 8'd1;
                    end
                    csq_pkg::OP_SQM_MUL: begin
                        r_e <= ar_res;
                    end
                    csq_pkg::OP_SQM_SQR: begin
                        r_pw <= ar_res;
                        r_k  <= r_k + 8'd1;
                    end
                    csq_pkg::OP_LEAD_ZE: begin
                        r_t <= ar_res;
                    end
                    csq_pkg::OP_LEAD_PHI: begin
                        r_t    <= ar_res;
                        r_lead <= ar_res;
                    end
                    csq_pkg::OP_NRM_STEP: begin
                        r_t <= ar_res;
                        r_k <= r_k + 8'd2;
                        if (ar_res == 64'd0) begin
                            r_nz <= 1'b1;
                            r_p  <= csq_pkg::Q62_HALF -
                                    ((r_p > csq_pkg::Q62_HALF) ? csq_pkg::Q62_HALF : r_p);
                        end else begin
                            r_p <= r_p + ar_res;
                        end
                    end
                    csq_pkg::OP_SER_STEP: begin
                        r_t <= ar_res;
                        r_s <= r_s + ar_res;
                        r_k <= r_k + 8'd2;
                    end
                    default: begin
                        r_done <= 1'b1;
                    end
                endcase
            end
            if (i_cmd.go) begin
                case (i_cmd.op)
                    csq_pkg::OP_EXP_INIT_F: begin
                        r_t    <= csq_pkg::Q62_ONE;
                        r_k    <= csq_pkg::EXP_TERMS;
                        r_f1   <= 1'b0;
                        r_done <= 1'b1;
                    end
                    csq_pkg::OP_EXP_INIT_1: begin
                        r_e    <= r_t;
                        r_t    <= csq_pkg::Q62_ONE;
                        r_k    <= csq_pkg::EXP_TERMS;
                        r_f1   <= 1'b1;
                        r_done <= 1'b1;
                    end
                    csq_pkg::OP_SQM_INIT: begin
                        r_pw   <= r_t;
                        r_k    <= 8'd0;
                        r_done <= 1'b1;
                    end
                    csq_pkg::OP_SQM_MUL: begin
                        if (!exp_bit) begin
                            r_done <= 1'b1;
                        end
                    end
                    csq_pkg::OP_SQRT: begin
                        r_sv    <= {2'b0, r_x, 40'b0};
                        r_sres  <= '0;
                        r_sbit  <= csq_pkg::SQRT_BIT0;
                        r_scnt  <= '0;
                        r_sbusy <= 1'b1;
                    end
                    csq_pkg::OP_NRM_INIT: begin
                        r_t    <= r_lead;
                        r_p    <= r_lead;
                        r_k    <= 8'd3;
                        r_nz   <= 1'b0;
                        r_done <= 1'b1;
                    end
                    csq_pkg::OP_NRM_FAIL: begin
                        r_p    <= (r_z != 64'd0) ? 64'd0 : csq_pkg::Q62_HALF;
                        r_done <= 1'b1;
                    end
                    csq_pkg::OP_ODD_INIT: begin
                        r_s    <= (r_df > 8'd1) ? r_lead : 64'd0;
                        r_t    <= r_lead;
                        r_k    <= 8'd3;
                        r_done <= 1'b1;
                    end
                    csq_pkg::OP_EVEN_INIT: begin
                        r_s    <= r_e;
                        r_t    <= r_e;
                        r_k    <= 8'd2;
                        r_done <= 1'b1;
                    end
                    csq_pkg::OP_FINISH: begin
                        r_s    <= r_df[0] ? {sum_pq[62:0], 1'b0} : r_s;
                        r_done <= 1'b1;
                    end
                    default: begin
                        r_sbusy <= r_sbusy;
                    end
                endcase
            end
        end
    end

    // clamp to 1.0 and round half up to Q1.31
    assign q_clamp = (r_s > csq_pkg::Q62_ONE) ? csq_pkg::Q62_ONE : r_s;
    assign q_rnd   = q_clamp + csq_pkg::RND_HALF;
    assign up      = q_rnd[62:31];

    assign o_out.upper_prob = up;
    assign o_out.lower_prob = csq_pkg::Q31_ONE - up;

    assign o_status.done     = r_done;
    assign o_status.k_zero   = (r_k == 8'd0);
    assign o_status.k_lt_exp = (r_k < csq_pkg::EXP_BITS);
    assign o_status.k_lt_df  = (r_k < r_df);
    assign o_status.k_lt_nrm = (r_k < NRM_LIM);
    assign o_status.odd      = r_df[0];
    assign o_status.nrm_conv = r_nz;

endmodule

@@ src/csq_ctrl.sv @@
module csq_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic              i_out_free,
    input  csq_pkg::t_status  i_status,
    output csq_pkg::t_cmd     o_cmd,
    output logic              o_emit
);

    typedef enum logic [1:0] {S_IDLE, S_RUN, S_EMIT} t_state;

    t_state        r_state;
    csq_pkg::t_op  r_op;
    logic          r_go;
    csq_pkg::t_op  nxt_op;
    logic          nxt_fin;

    // pick the next micro-op once the current one reports done
    always_comb begin
        nxt_op  = r_op;
        nxt_fin = 1'b0;
        case (r_op)
            csq_pkg::OP_EXP_INIT_F: nxt_op = csq_pkg::OP_EXP_STEP_F;
            csq_pkg::OP_EXP_STEP_F: begin
                nxt_op = i_status.k_zero ? csq_pkg::OP_EXP_INIT_1 : csq_pkg::OP_EXP_STEP_F;
            end
            csq_pkg::OP_EXP_INIT_1: nxt_op = csq_pkg::OP_EXP_STEP_1;
            csq_pkg::OP_EXP_STEP_1: begin
                nxt_op = i_status.k_zero ? csq_pkg::OP_SQM_INIT : csq_pkg::OP_EXP_STEP_1;
            end
            csq_pkg::OP_SQM_INIT: nxt_op = csq_pkg::OP_SQM_MUL;
            csq_pkg::OP_SQM_MUL:  nxt_op = csq_pkg::OP_SQM_SQR;
            csq_pkg::OP_SQM_SQR: begin
                if (i_status.k_lt_exp) begin
                    nxt_op = csq_pkg::OP_SQM_MUL;
                end else begin
                    nxt_op = i_status.odd ? csq_pkg::OP_SQRT : csq_pkg::OP_EVEN_INIT;
                end
            end
            csq_pkg::OP_SQRT:     nxt_op = csq_pkg::OP_LEAD_ZE;
            csq_pkg::OP_LEAD_ZE:  nxt_op = csq_pkg::OP_LEAD_PHI;
            csq_pkg::OP_LEAD_PHI: nxt_op = csq_pkg::OP_NRM_INIT;
            csq_pkg::OP_NRM_INIT: nxt_op = csq_pkg::OP_NRM_STEP;
            csq_pkg::OP_NRM_STEP: begin
                if (i_status.nrm_conv) begin
                    nxt_op = csq_pkg::OP_ODD_INIT;
                end else begin
                    nxt_op = i_status.k_lt_nrm ? csq_pkg::OP_NRM_STEP : csq_pkg::OP_NRM_FAIL;
                end
            end
            csq_pkg::OP_NRM_FAIL: nxt_op = csq_pkg::OP_ODD_INIT;
            csq_pkg::OP_ODD_INIT, csq_pkg::OP_EVEN_INIT, csq_pkg::OP_SER_STEP: begin
                nxt_op = i_status.k_lt_df ? csq_pkg::OP_SER_STEP : csq_pkg::OP_FINISH;
            end
            default: nxt_fin = 1'b1;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_go    <= 1'b0;
            r_op    <= csq_pkg::OP_EXP_INIT_F;
        end else begin
            r_go <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_op    <= csq_pkg::OP_EXP_INIT_F;
                        r_go    <= 1'b1;
                        r_state <= S_RUN;
                    end
                end
                S_RUN: begin
                    if (i_status.done) begin
                        if (nxt_fin) begin
                            r_state <= S_EMIT;
                        end else begin
                            r_op <= nxt_op;
                            r_go <= 1'b1;
                        end
                    end
                end
                S_EMIT: begin
                    if (i_out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_in_ready = (r_state == S_IDLE);
    assign o_emit     = (r_state == S_EMIT) && i_out_free;
    assign o_cmd.go   = r_go;
    assign o_cmd.op   = r_op;

endmodule
